/* sv/indexed_insert_remove_list_top_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the indexed insert/remove list
// Concurrent check wrappers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef INDEXED_INSERT_REMOVE_LIST_TOP_DEFINES_SVH
`define INDEXED_INSERT_REMOVE_LIST_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication check.
`define ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication check.
`define ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_IMP(lbl, ante, cons, msg)
`define ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

/* sv/iirl_pkg.sv */
// ----------------------------------------------------------------------------
// Indexed insert/remove list package
// Shared types, operation and status codes, and default sizes.
// ----------------------------------------------------------------------------
package iirl_pkg;

	localparam int DEF_CAPACITY  = 16;
	localparam int DEF_WORD_BITS = 32;
	localparam int POS_BITS      = 5;
	localparam int IN_WORD_BITS  = 32;
	localparam int LEN_BITS      = 5;
	localparam int MAX_WORD_BITS = 64;

	typedef enum logic [1:0] {
		OP_APPEND = 2'd0,
		OP_INSERT = 2'd1,
		OP_REMOVE = 2'd2,
		OP_GET    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	// Per-cycle command broadcast to every cell of the row.
	typedef struct packed {
		logic shift_back;  // cells after the target take their left neighbor
		logic shift_fwd;   // cells at and after the target take their right neighbor
		logic load;        // the cell at the target takes the new word
	} iirl_cmd_t;

endpackage

/* sv/iirl_cell.sv */
// ----------------------------------------------------------------------------
// List cell
// Holds one entry and updates it from a neighbor or the new word.
// ----------------------------------------------------------------------------
module iirl_cell import iirl_pkg::*; #(
	parameter int WORD_BITS = DEF_WORD_BITS,
	parameter int CMP_W     = POS_BITS,
	parameter int IDX       = 0
) (
	input  logic                 clk,
	input  iirl_cmd_t            cmd,
	input  logic [CMP_W-1:0]     target,
	input  logic [WORD_BITS-1:0] word,
	input  logic [WORD_BITS-1:0] left,
	input  logic [WORD_BITS-1:0] right,
	output logic [WORD_BITS-1:0] q
);

	logic [CMP_W-1:0] my_idx;
	logic             at_target;
	logic             past_target;

	assign my_idx      = CMP_W'(IDX);
	assign at_target   = (my_idx == target);
	assign past_target = (my_idx > target);

	// The new word has priority at the target; insert shifts the tail back,
	// remove pulls the tail forward over the removed entry.
	always_ff @(posedge clk) begin
		priority if (cmd.load && at_target) begin
			q <= word;
		end else if (cmd.shift_back && past_target) begin
			q <= left;
		end else if (cmd.shift_fwd && (past_target || at_target)) begin
			q <= right;
		end else begin
			q <= q;
		end
	end

endmodule

/* sv/iirl_ctrl.sv */
// ----------------------------------------------------------------------------
// List control
// Checks each operation, holds the entry count and drives the cell row.
// ----------------------------------------------------------------------------
module iirl_ctrl import iirl_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY,
	parameter int CNT_W    = $clog2(DEF_CAPACITY + 1),
	parameter int CMP_W    = POS_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [1:0]          operation,
	input  logic [POS_BITS-1:0] position,
	output iirl_cmd_t           cmd,
	output logic [CMP_W-1:0]    target,
	output status_t             status,
	output logic                get_ok,
	output logic [CNT_W-1:0]    count_next,
	output logic [CNT_W-1:0]    count
);

	logic [CNT_W-1:0] count_q;
	logic [CMP_W-1:0] cnt_x;
	logic [CMP_W-1:0] pos_x;
	logic             full;
	op_t              op;

	assign op    = op_t'(operation);
	assign cnt_x = CMP_W'(count_q);
	assign pos_x = CMP_W'(position);
	assign full  = (count_q == CNT_W'(CAPACITY));
	assign count = count_q;

	always_comb begin
		cmd        = '0;
		target     = pos_x;
		status     = ST_OK;
		get_ok     = 1'b0;
		count_next = count_q;
		unique case (op)
			OP_APPEND: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					target     = cnt_x;
					cmd.load   = accept;
					count_next = count_q + CNT_W'(1);
				end
			end
			OP_INSERT: begin
				// The index is checked before capacity.
				if (pos_x > cnt_x) begin
					status = ST_RANGE;
				end else if (full) begin
					status = ST_FULL;
				end else begin
					cmd.load       = accept;
					cmd.shift_back = accept;
					count_next     = count_q + CNT_W'(1);
				end
			end
			OP_REMOVE: begin
				if (pos_x >= cnt_x) begin
					status = ST_RANGE;
				end else begin
					cmd.shift_fwd = accept;
					count_next    = count_q - CNT_W'(1);
				end
			end
			OP_GET: begin
				if (pos_x >= cnt_x) begin
					status = ST_RANGE;
				end else begin
					get_ok = 1'b1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_next;
		end
	end

endmodule

/* sv/indexed_insert_remove_list_top.sv */
// ----------------------------------------------------------------------------
// Indexed insert/remove list, top level
// Ordered list of data words with append, insert, remove and get by index.
// ----------------------------------------------------------------------------
// The result of an item appears in the cycle after it is accepted.
// Throughput: one item per cycle; busy stays low, since every cell of the row
// moves its entry to or from its neighbor in the same cycle.
// The result strobe done lasts one cycle and the receiver cannot stall it.
// Reset (arst_n low) empties the list at once; entry contents are not reset.
// ----------------------------------------------------------------------------
`include "indexed_insert_remove_list_top_defines.svh"

module indexed_insert_remove_list_top import iirl_pkg::*; #(
	parameter int CAPACITY  = DEF_CAPACITY,
	parameter int WORD_BITS = DEF_WORD_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [1:0]              operation,
	input  logic [POS_BITS-1:0]     position,
	input  logic [IN_WORD_BITS-1:0] item_word,
	output logic                    done,
	output logic [IN_WORD_BITS-1:0] read_word,
	output logic [LEN_BITS-1:0]     list_length,
	output logic [1:0]              status
);

	// Count needs to hold CAPACITY itself; compares run at a width that fits
	// both the count and the position field.
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > POS_BITS) ? CNT_W : POS_BITS;
	localparam int IDX_W = $clog2(CAPACITY);

	logic                 accept;
	iirl_cmd_t            cmd;
	logic [CMP_W-1:0]     target;
	status_t              status_c;
	logic                 get_ok;
	logic [CNT_W-1:0]     count_next;
	logic [CNT_W-1:0]     count;
	logic [WORD_BITS-1:0] new_word;
	logic [WORD_BITS-1:0] cell_q [CAPACITY];
	logic [WORD_BITS-1:0] rd_sel;
	logic [MAX_WORD_BITS-1:0] in_ext;
	logic [MAX_WORD_BITS-1:0] rd_ext;
	logic [CMP_W-1:0]     pos_x;
	logic [CMP_W-1:0]     len_ext;

	// Result registers.
	logic                    done_s1;
	logic [IN_WORD_BITS-1:0] rd_s1;
	logic [LEN_BITS-1:0]     len_s1;
	status_t                 st_s1;

	// Every operation completes in the cycle it is accepted.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// The stored word keeps the low WORD_BITS bits of the input word.
	assign in_ext   = MAX_WORD_BITS'(item_word);
	assign new_word = in_ext[WORD_BITS-1:0];

	iirl_ctrl #(
		.CAPACITY (CAPACITY),
		.CNT_W    (CNT_W),
		.CMP_W    (CMP_W)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.operation  (operation),
		.position   (position),
		.cmd        (cmd),
		.target     (target),
		.status     (status_c),
		.get_ok     (get_ok),
		.count_next (count_next),
		.count      (count)
	);

	// The row of cells. The first cell never takes a left neighbor, and the
	// last cell's right input is its own entry: whatever lands there on a
	// remove lies beyond the new count and is never read.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [WORD_BITS-1:0] left_w;
		logic [WORD_BITS-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = new_word;
		end else begin : g_mid_l
			assign left_w = cell_q[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_w = cell_q[i];
		end else begin : g_mid_r
			assign right_w = cell_q[i+1];
		end

		iirl_cell #(
			.WORD_BITS (WORD_BITS),
			.CMP_W     (CMP_W),
			.IDX       (i)
		) u_cell (
			.clk    (clk),
			.cmd    (cmd),
			.target (target),
			.word   (new_word),
			.left   (left_w),
			.right  (right_w),
			.q      (cell_q[i])
		);
	end

	// Get reads the entry at the position. The select is only used when the
	// position is below the count, so it always lands on a real cell.
	assign pos_x  = CMP_W'(position);
	assign rd_sel = cell_q[pos_x[IDX_W-1:0]];
	assign rd_ext = MAX_WORD_BITS'(rd_sel);

	assign len_ext = CMP_W'(count_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1 <= 1'b0;
		end else begin
			done_s1 <= accept;
		end
	end

	// The payload registers load on every accepted item and need no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1  <= get_ok ? rd_ext[IN_WORD_BITS-1:0] : '0;
			len_s1 <= len_ext[LEN_BITS-1:0];
			st_s1  <= status_c;
		end
	end

	assign done        = done_s1;
	assign read_word   = rd_s1;
	assign list_length = len_s1;
	assign status      = st_s1;

	// Every accepted item yields a result strobe in the next cycle.
	`ASSERT_NXT(a_done_follows, accept, done, "result strobe missing after an accepted item")
	// The count never goes beyond the capacity.
	`ASSERT_IMP(a_count_bound, 1'b1, count <= CNT_W'(CAPACITY), "entry count exceeds capacity")
	// A rejected operation leaves the count untouched.
	`ASSERT_NXT(a_reject_holds, accept && (status_c != ST_OK), count == $past(count),
		"entry count changed on a rejected operation")
	// A failed or non-get operation reports a zero read word.
	`ASSERT_NXT(a_rd_zero, accept && !get_ok, read_word == '0,
		"read word not zero without a successful get")

endmodule
